[rtl/url_form_decoder_assert.svh]
// assertion macros used by the checker file
`ifndef URL_FORM_DECODER_ASSERT_SVH
`define URL_FORM_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define URL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define URL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/url_dec_pkg.sv]
// types, character codes and hex helpers for the form decoder
package url_dec_pkg;

	localparam int MAX_RESULTS = 3;
	localparam int CNT_W = 2;

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_EQ    = 8'h3D;
	localparam logic [7:0] CHAR_AMP   = 8'h26;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// escape tracking: idle, percent seen, percent and first digit seen
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HEX1 = 2'd2
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic       in_value_field;
		logic       string_end;
		logic       last_of_run;
	} result_t;

	// all results caused by one byte, slot 0 first
	typedef struct packed {
		logic [CNT_W-1:0]             count;
		result_t [MAX_RESULTS-1:0]    res;
	} decode_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	// nibble value of a hex digit, zero for anything else
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = c - 8'h57;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = c - 8'h37;
		end
		return d[3:0];
	endfunction

	function automatic result_t mk_result(input logic kind, input logic [7:0] data,
		input logic value_field, input logic send);
		result_t r;
		r.kind = kind;
		r.out_byte = (kind == KIND_END) ? 8'h00 : data;
		r.in_value_field = value_field;
		r.string_end = send;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

[rtl/url_form_decoder.sv]
// form-urlencoded decoder top level
// a byte accepted passes through the input stage and then the result queue
// throughput: one byte per cycle while out_ready is high and each byte yields
// at most one result; otherwise the queue is held until the byte's last result leaves
// reset: arst_n clears the input stage, the queue count and the escape and field state
module url_form_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       terminator,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       kind,
	output logic [7:0] out_byte,
	output logic       in_value_field,
	output logic       string_end,
	output logic       last_of_run
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 term_s1;
	logic                 move;
	logic                 free;
	url_dec_pkg::decode_t dec;
	url_dec_pkg::result_t head;

	assign move = valid_s1 && free;
	assign in_ready = !valid_s1 || move;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			term_s1 <= terminator;
		end
	end

	url_dec_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (move),
		.in_byte    (byte_s1),
		.terminator (term_s1),
		.dec        (dec)
	);

	url_dec_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (move),
		.dec       (dec),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.free      (free)
	);

	assign kind = head.kind;
	assign out_byte = head.out_byte;
	assign in_value_field = head.in_value_field;
	assign string_end = head.string_end;
	assign last_of_run = head.last_of_run;

endmodule

[rtl/url_dec_core.sv]
// escape and separator decoding with the decoder state registers
module url_dec_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           in_byte,
	input  logic                 terminator,
	output url_dec_pkg::decode_t dec
);

	url_dec_pkg::phase_t phase_q, next_phase;
	logic [7:0]          first_q, next_first;
	logic                toggle_q, next_toggle;

	// decode one byte into up to three results
	always_comb begin
		logic [url_dec_pkg::CNT_W-1:0] n;
		logic                          flush;
		logic                          plain;
		logic                          esc_done;
		logic                          hex;
		n = '0;
		flush = 1'b0;
		plain = 1'b0;
		esc_done = 1'b0;
		hex = url_dec_pkg::is_hex(in_byte);
		next_phase = url_dec_pkg::PH_IDLE;
		next_first = first_q;
		next_toggle = toggle_q;
		dec = '0;

		if (terminator) begin
			flush = 1'b1;
			next_toggle = 1'b0;
		end else begin
			unique case (phase_q)
				url_dec_pkg::PH_PCT: begin
					if (hex) begin
						next_first = in_byte;
						next_phase = url_dec_pkg::PH_HEX1;
					end else begin
						flush = 1'b1;
						plain = 1'b1;
					end
				end
				url_dec_pkg::PH_HEX1: begin
					if (hex) begin
						esc_done = 1'b1;
					end else begin
						flush = 1'b1;
						plain = 1'b1;
					end
				end
				default: begin
					plain = 1'b1;
				end
			endcase
		end

		// held escape bytes go out literally
		if (flush && (phase_q == url_dec_pkg::PH_PCT || phase_q == url_dec_pkg::PH_HEX1)) begin
			dec.res[n] = url_dec_pkg::mk_result(url_dec_pkg::KIND_DATA,
				url_dec_pkg::CHAR_PCT, toggle_q, 1'b0);
			n = n + 1'b1;
		end
		if (flush && phase_q == url_dec_pkg::PH_HEX1) begin
			dec.res[n] = url_dec_pkg::mk_result(url_dec_pkg::KIND_DATA, first_q,
				toggle_q, 1'b0);
			n = n + 1'b1;
		end

		// final field end of the string
		if (terminator) begin
			dec.res[n] = url_dec_pkg::mk_result(url_dec_pkg::KIND_END, 8'h00,
				toggle_q, 1'b1);
			n = n + 1'b1;
		end

		// completed two-digit escape
		if (esc_done) begin
			dec.res[n] = url_dec_pkg::mk_result(url_dec_pkg::KIND_DATA,
				{url_dec_pkg::hex_val(first_q), url_dec_pkg::hex_val(in_byte)},
				toggle_q, 1'b0);
			n = n + 1'b1;
		end

		// ordinary byte handling
		if (plain) begin
			case (in_byte) inside
				url_dec_pkg::CHAR_EQ, url_dec_pkg::CHAR_AMP: begin
					dec.res[n] = url_dec_pkg::mk_result(url_dec_pkg::KIND_END, 8'h00,
						toggle_q, 1'b0);
					n = n + 1'b1;
					next_toggle = ~toggle_q;
				end
				url_dec_pkg::CHAR_PLUS: begin
					dec.res[n] = url_dec_pkg::mk_result(url_dec_pkg::KIND_DATA,
						url_dec_pkg::CHAR_SPACE, toggle_q, 1'b0);
					n = n + 1'b1;
				end
				url_dec_pkg::CHAR_PCT: begin
					next_phase = url_dec_pkg::PH_PCT;
				end
				default: begin
					dec.res[n] = url_dec_pkg::mk_result(url_dec_pkg::KIND_DATA, in_byte,
						toggle_q, 1'b0);
					n = n + 1'b1;
				end
			endcase
		end

		// mark the last result of the run
		if (n != '0) begin
			dec.res[n - 1'b1].last_of_run = 1'b1;
		end
		dec.count = n;
	end

	// decoder state advances when the byte moves into the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= url_dec_pkg::PH_IDLE;
			first_q <= 8'h00;
			toggle_q <= 1'b0;
		end else if (advance) begin
			phase_q <= next_phase;
			first_q <= next_first;
			toggle_q <= next_toggle;
		end
	end

endmodule

[rtl/url_dec_outq.sv]
// result queue holding the results of one byte, drained one per cycle while out_ready is high
module url_dec_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  url_dec_pkg::decode_t dec,
	input  logic                 out_ready,
	output logic                 out_valid,
	output url_dec_pkg::result_t head,
	output logic                 free
);

	url_dec_pkg::result_t [url_dec_pkg::MAX_RESULTS-1:0] queue_q;
	logic [url_dec_pkg::CNT_W-1:0]                        cnt_q;
	logic                                                 pop;

	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && out_ready;
	assign head = queue_q[0];
	// room for a new run when empty or when the last result leaves now
	assign free = (cnt_q == '0) || (cnt_q == 2'd1 && out_ready);

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= dec.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// result payload, shifts toward the head on each transaction
	always_ff @(posedge clk) begin
		if (load) begin
			queue_q <= dec.res;
		end else if (pop) begin
			queue_q[0] <= queue_q[1];
			queue_q[1] <= queue_q[2];
			queue_q[2] <= '0;
		end
	end

endmodule

[rtl/url_dec_checker.sv]
// port-level checks for the form decoder, bound to the top level
`include "url_form_decoder_assert.svh"

module url_dec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       kind,
	input logic [7:0] out_byte,
	input logic       in_value_field,
	input logic       string_end,
	input logic       last_of_run
);

	// a stalled result holds
	`URL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(kind))

	// results of one run follow without a gap
	`URL_ASSERT_NEXT(a_run_continues, clk, arst_n, out_valid && out_ready && !last_of_run,
		out_valid)

	// one run stays in one field
	`URL_ASSERT_NEXT(a_run_same_field, clk, arst_n, out_valid && out_ready && !last_of_run,
		in_value_field == $past(in_value_field))

	// the string end is a field end that closes its run
	`URL_ASSERT_NOW(a_end_closes_run, clk, arst_n, out_valid && string_end,
		kind && last_of_run && out_byte == 8'h00)

endmodule

bind url_form_decoder url_dec_checker u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.kind           (kind),
	.out_byte       (out_byte),
	.in_value_field (in_value_field),
	.string_end     (string_end),
	.last_of_run    (last_of_run)
);
